>>> rtl/dmrw_pkg.sv
// Shared types, constants and helpers for the dual motor ramp block.
// No dependencies; imported by dmrw_side and the top level.
`default_nettype none

package dmrw_pkg;

   localparam int TIME_BITS_DEF  = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int STEP_W         = 7;
   localparam int TICKS_W        = 32;
   localparam int LEVEL_W        = 8;
   localparam int DUTY_W         = 7;
   localparam int KICK_W         = 32;

   typedef logic signed [LEVEL_W-1:0] level_type;
   typedef logic [DUTY_W-1:0]         duty_type;
   typedef logic [STEP_W-1:0]         step_type;

   localparam level_type LEVEL_MAX = 8'sd100;
   localparam level_type LEVEL_MIN = -8'sd100;

   localparam step_type  SLEW_LIMIT_RST     = 7'd5;
   localparam logic [TICKS_W-1:0] TIMEOUT_RST  = 32'd1000000;
   localparam logic [TICKS_W-1:0] INTERVAL_RST = 32'd40000;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_SET  = 2'd1,
      KIND_KICK = 2'd2,
      KIND_STOP = 2'd3
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SLEW_LIMIT   = 3'd0,
      CSR_TIMEOUT      = 3'd1,
      CSR_INTERVAL     = 3'd2,
      CSR_LEFT_INVERT  = 3'd3,
      CSR_RIGHT_INVERT = 3'd4
   } csr_addr_type;

   // per-side control from the item decode
   typedef struct packed {
      logic step_en;
      logic clear;
   } side_ctl_type;

   function automatic level_type clamp_level(input level_type v);
      level_type r;
      if (v > LEVEL_MAX) begin
         r = LEVEL_MAX;
      end else if (v < LEVEL_MIN) begin
         r = LEVEL_MIN;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/dmrw_side.sv
// One drive side: slew-limited move toward the goal and PWM duty split.
// Depends on dmrw_pkg.
`default_nettype none

module dmrw_side
   import dmrw_pkg::*;
(
   input  level_type    cur_level,
   input  level_type    goal,
   input  step_type     slew_limit,
   input  logic         invert,
   input  side_ctl_type ctl,
   output level_type    next_level,
   output duty_type     fwd_duty,
   output duty_type     rev_duty
);

   logic signed [LEVEL_W:0] goal_eff;
   logic signed [LEVEL_W:0] delta;
   logic signed [LEVEL_W:0] lim;
   logic signed [LEVEL_W:0] sum;
   level_type               moved;
   level_type               drive;
   level_type               drive_neg;

   always_comb begin
      // reversal ramps to zero first
      if (cur_level != 0 && goal != 0 && (cur_level[LEVEL_W-1] != goal[LEVEL_W-1])) begin
         goal_eff = '0;
      end else begin
         goal_eff = (LEVEL_W+1)'(goal);
      end
      lim   = (LEVEL_W+1)'({2'b00, slew_limit});
      delta = goal_eff - (LEVEL_W+1)'(cur_level);
      if (delta > lim) begin
         delta = lim;
      end
      if (delta < -lim) begin
         delta = -lim;
      end
      sum = (LEVEL_W+1)'(cur_level) + delta;
      if (sum > (LEVEL_W+1)'(LEVEL_MAX)) begin
         moved = LEVEL_MAX;
      end else if (sum < (LEVEL_W+1)'(LEVEL_MIN)) begin
         moved = LEVEL_MIN;
      end else begin
         moved = sum[LEVEL_W-1:0];
      end

      if (ctl.clear) begin
         next_level = '0;
      end else if (ctl.step_en) begin
         next_level = moved;
      end else begin
         next_level = cur_level;
      end

      drive     = invert ? -next_level : next_level;
      drive_neg = -drive;
      fwd_duty  = '0;
      rev_duty  = '0;
      if (drive > 0) begin
         fwd_duty = drive[DUTY_W-1:0];
      end else if (drive < 0) begin
         rev_duty = drive_neg[DUTY_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> rtl/dual_motor_ramp_with_watchdog_top.sv
// Top level of the two-channel motor ramp limiter with command watchdog.
// Depends on dmrw_pkg and dmrw_side.
`default_nettype none

// Takes one word per cycle while rsp_tready stays high and returns one result
// word per input word. A word sits in the input register, where tick, target,
// kick or stop is applied to the state in a single pass, and the result is then
// held in the output register; throughput is one word per cycle while rsp_tready
// stays high. The rate is set by the state update loop (time counter add,
// watchdog and interval compares, level step).
module dual_motor_ramp_with_watchdog_top
   import dmrw_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // left_target, right_target, kick_time
   input  logic [1:0]            req_tuser,   // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // left_fwd, left_rev, right_fwd, right_rev, pad
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CMP_W = (TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W;
   localparam int EXT_W = (TIME_BITS > KICK_W) ? TIME_BITS : KICK_W;

   // configuration
   step_type             slew_limit_ff;
   logic [TICKS_W-1:0]   timeout_ff;
   logic [TICKS_W-1:0]   interval_ff;
   logic                 left_inv_ff;
   logic                 right_inv_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   kind_type             in_kind_ff;
   level_type            in_left_ff;
   level_type            in_right_ff;
   logic [KICK_W-1:0]    in_kick_ff;

   // state
   level_type            left_level_ff, left_level_in;
   level_type            right_level_ff, right_level_in;
   level_type            left_goal_ff, left_goal_in;
   level_type            right_goal_ff, right_goal_in;
   logic [TIME_BITS-1:0] time_now_ff, time_now_in;
   logic [TIME_BITS-1:0] last_kick_ff, last_kick_in;
   logic [TIME_BITS-1:0] last_step_ff, last_step_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   duty_type             lf_ff, lr_ff, rf_ff, rr_ff;

   logic                 req_fire;
   logic                 advance;
   logic [TIME_BITS-1:0] time_next;
   logic [TIME_BITS-1:0] kick_elapsed;
   logic [TIME_BITS-1:0] step_elapsed;
   logic                 wd_fire;
   logic                 step_fire;
   logic [EXT_W-1:0]     kick_ext;
   level_type            left_goal_eff, right_goal_eff;
   side_ctl_type         side_ctl;
   level_type            left_next, right_next;
   duty_type             lf_in, lr_in, rf_in, rr_in;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, rr_ff, rf_ff, lr_ff, lf_ff};

   assign time_next    = time_now_ff + TIME_BITS'(1);
   assign kick_elapsed = time_next - last_kick_ff;
   assign step_elapsed = time_next - last_step_ff;
   assign wd_fire      = CMP_W'(kick_elapsed) > CMP_W'(timeout_ff);
   assign step_fire    = CMP_W'(step_elapsed) >= CMP_W'(interval_ff);
   assign kick_ext     = EXT_W'(in_kick_ff);

   always_comb begin
      time_now_in    = time_now_ff;
      last_kick_in   = last_kick_ff;
      last_step_in   = last_step_ff;
      left_goal_in   = left_goal_ff;
      right_goal_in  = right_goal_ff;
      left_goal_eff  = left_goal_ff;
      right_goal_eff = right_goal_ff;
      side_ctl       = '0;
      unique case (in_kind_ff)
         KIND_TICK: begin
            time_now_in = time_next;
            if (wd_fire) begin
               left_goal_eff  = '0;
               right_goal_eff = '0;
            end
            left_goal_in  = left_goal_eff;
            right_goal_in = right_goal_eff;
            if (step_fire) begin
               last_step_in     = time_next;
               side_ctl.step_en = 1'b1;
            end
         end
         KIND_SET: begin
            left_goal_in  = clamp_level(in_left_ff);
            right_goal_in = clamp_level(in_right_ff);
         end
         KIND_KICK: begin
            last_kick_in = kick_ext[TIME_BITS-1:0];
         end
         KIND_STOP: begin
            left_goal_in   = '0;
            right_goal_in  = '0;
            side_ctl.clear = 1'b1;
         end
         default: begin
         end
      endcase
   end

   dmrw_side u_left (
      .cur_level  (left_level_ff),
      .goal       (left_goal_eff),
      .slew_limit (slew_limit_ff),
      .invert     (left_inv_ff),
      .ctl        (side_ctl),
      .next_level (left_next),
      .fwd_duty   (lf_in),
      .rev_duty   (lr_in)
   );

   dmrw_side u_right (
      .cur_level  (right_level_ff),
      .goal       (right_goal_eff),
      .slew_limit (slew_limit_ff),
      .invert     (right_inv_ff),
      .ctl        (side_ctl),
      .next_level (right_next),
      .fwd_duty   (rf_in),
      .rev_duty   (rr_in)
   );

   assign left_level_in  = left_next;
   assign right_level_in = right_next;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         left_level_ff  <= '0;
         right_level_ff <= '0;
         left_goal_ff   <= '0;
         right_goal_ff  <= '0;
         time_now_ff    <= '0;
         last_kick_ff   <= '0;
         last_step_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            left_level_ff  <= left_level_in;
            right_level_ff <= right_level_in;
            left_goal_ff   <= left_goal_in;
            right_goal_ff  <= right_goal_in;
            time_now_ff    <= time_now_in;
            last_kick_ff   <= last_kick_in;
            last_step_ff   <= last_step_in;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slew_limit_ff <= SLEW_LIMIT_RST;
         timeout_ff    <= TIMEOUT_RST;
         interval_ff   <= INTERVAL_RST;
         left_inv_ff   <= 1'b0;
         right_inv_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SLEW_LIMIT:   slew_limit_ff <= csr_wdata[STEP_W-1:0];
            CSR_TIMEOUT:      timeout_ff    <= csr_wdata[TICKS_W-1:0];
            CSR_INTERVAL:     interval_ff   <= csr_wdata[TICKS_W-1:0];
            CSR_LEFT_INVERT:  left_inv_ff   <= csr_wdata[0];
            CSR_RIGHT_INVERT: right_inv_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff  <= kind_type'(req_tuser);
         in_left_ff  <= req_tdata[7:0];
         in_right_ff <= req_tdata[15:8];
         in_kick_ff  <= req_tdata[47:16];
      end
      if (advance) begin
         lf_ff <= lf_in;
         lr_ff <= lr_in;
         rf_ff <= rf_in;
         rr_ff <= rr_in;
      end
   end

endmodule

`default_nettype wire
